@@ design/bcam_pkg.sv @@
// package for the buffer congestion alarm monitor
// message kinds, controller states, command and status structs; no dependencies
package bcam_pkg;

    localparam int unsigned MaxDescReset = 65534;
    localparam int unsigned ClearRunReset = 6;

    typedef enum logic [2:0] {
        MSG_INIT    = 3'd0,
        MSG_CLEAR   = 3'd1,
        MSG_WARNING = 3'd2,
        MSG_ALERT   = 3'd3,
        MSG_UPDATE  = 3'd4
    } msg_kind_t;

    typedef enum logic [1:0] {
        REG_MAX_DESC  = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_CLEAR_RUN = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EVAL,
        ST_EMIT_INIT,
        ST_EMIT_UPDATE,
        ST_EMIT_STATE
    } ctrl_state_t;

    typedef struct packed {
        logic load;       // capture sample, start division
        logic div_step;   // one quotient bit
        logic eval;       // run alarm and period logic
        logic emit;       // present a message word
        msg_kind_t kind;  // which message to present
        logic last;       // final word of this sample
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic need_init;
        logic need_update;
        logic need_state;
    } dp_status_t;

endpackage

@@ design/bcam_datapath.sv @@
// datapath: serial divider, alarm level, period counters, output register
// depends on bcam_pkg
module bcam_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_value,
    input  logic [23:0]         free_in,
    input  logic [31:0]         rej_in,
    input  bcam_pkg::dp_cmd_t   cmd,
    output bcam_pkg::dp_status_t status,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [127:0]        out_data,
    output logic                out_last
);
    localparam int QBits = 31;

    logic [23:0] max_desc_reg;
    logic [6:0]  thresh_reg;
    logic [7:0]  clr_run_reg;

    logic        seen_reg, seen_next;
    logic [23:0] prev_free_reg, prev_free_next;
    logic [31:0] rej_sum_reg, rej_sum_next;
    logic [1:0]  level_reg, level_next;
    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  clean_reg, clean_next;
    logic [8:0]  psamp_reg, psamp_next;
    logic [8:0]  pbad_reg, pbad_next;
    logic [8:0]  pcnt_reg [3];
    logic [8:0]  pcnt_next [3];
    logic [7:0]  pim_reg, pim_next;
    logic [7:0]  bpim_reg, bpim_next;

    logic [23:0] free_reg;
    logic [31:0] rej_reg;
    logic [31:0] num_reg;     // free*100, shifted out msb first
    logic [24:0] rem_reg;
    logic [30:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic        upd_reg, state_reg;

    // state message snapshot
    logic [1:0]  smsg_level_reg;
    logic [8:0]  smsg_cnt_reg [3];
    logic [1:0]  smsg_mode_reg;
    logic [6:0]  util_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_desc_reg <= 24'(bcam_pkg::MaxDescReset);
            thresh_reg   <= '0;
            clr_run_reg  <= 8'(bcam_pkg::ClearRunReset);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bcam_pkg::REG_MAX_DESC:  max_desc_reg <= cfg_value[23:0];
                bcam_pkg::REG_THRESHOLD: thresh_reg   <= cfg_value[6:0];
                bcam_pkg::REG_CLEAR_RUN: clr_run_reg  <= cfg_value[7:0];
                default: ;
            endcase
        end
    end

    // divider: restoring, one bit a cycle
    logic [24:0] rem_shift;
    logic [25:0] rem_sub;
    assign rem_shift = {rem_reg[23:0], num_reg[31]};
    assign rem_sub = {1'b0, rem_shift} - {2'b0, max_desc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.load)
            cnt_reg <= 5'(QBits);
        else if (cmd.div_step && cnt_reg != '0)
            cnt_reg <= cnt_reg - 5'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            free_reg <= free_in;
            rej_reg  <= rej_in;
            num_reg  <= {1'b0, 31'({7'd0, free_in} * 31'd100)} << 1;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            if (!rem_sub[25])
            begin
                rem_reg <= rem_sub[24:0];
                quo_reg <= {quo_reg[29:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[29:0], 1'b0};
            end
        end
    end
    assign status.div_done = (cnt_reg == '0);

    // evaluation of one sample
    logic        free_ge;
    logic [6:0]  util;
    logic        over;
    logic [1:0]  cls;
    logic [2:0]  ev;
    logic        fire_state;
    logic        fire_upd;
    logic [8:0]  need_samp;
    logic [7:0]  maxp;
    logic [1:0]  mi;
    logic [7:0]  pim_inc, bpim_inc;
    logic [8:0]  pbad_tmp;
    logic [1:0]  snap_level;
    logic [8:0]  snap_cnt [3];

    assign free_ge = (free_reg >= max_desc_reg);
    assign util = (max_desc_reg == '0 || free_ge) ? 7'd0 : 7'(7'd100 - quo_reg[6:0]);
    assign over = util > thresh_reg;
    assign cls = {rej_reg != '0, over};

    always_comb
    begin
        seen_next = seen_reg;
        prev_free_next = prev_free_reg;
        rej_sum_next = rej_sum_reg;
        level_next = level_reg;
        mode_next = mode_reg;
        clean_next = clean_reg;
        psamp_next = psamp_reg;
        pbad_next = pbad_reg;
        pcnt_next = pcnt_reg;
        pim_next = pim_reg;
        bpim_next = bpim_reg;
        fire_state = 1'b0;
        fire_upd = (prev_free_reg != free_reg) || (rej_reg != '0);
        ev = '0;
        mi = (mode_reg > 2'd2) ? 2'd2 : mode_reg;
        need_samp = (mi == 2'd0) ? 9'd1 : (mi == 2'd1) ? 9'd6 : 9'd360;
        maxp = (mi == 2'd2) ? 8'd1 : 8'd3;
        pim_inc = '0;
        bpim_inc = '0;
        pbad_tmp = '0;
        snap_level = level_reg;
        snap_cnt = pcnt_reg;
        if (cmd.eval)
        begin
            seen_next = 1'b1;
            rej_sum_next = rej_sum_reg + rej_reg;
            prev_free_next = free_reg;
            if (!(level_reg == 2'd0 && cls == 2'd0))
            begin
                if (cls != 2'd0)
                    ev = 3'({1'b0, cls} + 3'd1);
                else
                begin
                    clean_next = clean_reg + 8'd1;
                    if (clean_next >= clr_run_reg)
                        ev = 3'd1;
                end
                psamp_next = psamp_reg + 9'd1;
                if (cls != 2'd0)
                    pcnt_next[cls - 2'd1] = pcnt_reg[cls - 2'd1] + 9'd1;
                if (ev == 3'd1)
                    level_next = 2'd0;
                else if (ev >= 3'd2 && ev - 3'd1 > {1'b0, level_reg})
                    level_next = 2'(ev - 3'd1);
                snap_cnt = pcnt_next;
                snap_level = level_next;
                if (ev != 3'd0 && level_next != level_reg)
                begin
                    fire_state = 1'b1;
                    pim_next = (level_next != 2'd0) ? 8'd1 : 8'd0;
                    bpim_next = pim_next;
                    clean_next = '0;
                    psamp_next = '0;
                    pbad_next = '0;
                    pcnt_next = '{default: '0};
                    mode_next = '0;
                end
                else
                begin
                    pbad_tmp = pbad_reg;
                    if (cls != 2'd0)
                    begin
                        clean_next = '0;
                        if (!(level_reg != 2'd0 && ev < {1'b0, level_reg} + 3'd1))
                            pbad_tmp = pbad_reg + 9'd1;
                    end
                    pbad_next = pbad_tmp;
                    if (psamp_next >= need_samp)
                    begin
                        pim_inc = pim_reg + 8'd1;
                        pim_next = pim_inc;
                        if (pbad_tmp != '0)
                        begin
                            bpim_inc = bpim_reg + 8'd1;
                            bpim_next = bpim_inc;
                            fire_state = 1'b1;
                            if (pim_inc >= maxp || pim_inc != bpim_inc)
                            begin
                                pim_next = '0;
                                bpim_next = '0;
                                mode_next = (mi == 2'd0) ? 2'd1 : 2'd2;
                            end
                        end
                        else if (pim_inc >= (maxp >> 1))
                        begin
                            pim_next = '0;
                            bpim_next = '0;
                            mode_next = (mi == 2'd0) ? 2'd1 : 2'd2;
                        end
                        psamp_next = '0;
                        pbad_next = '0;
                        pcnt_next = '{default: '0};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            prev_free_reg <= '0;
            rej_sum_reg <= '0;
            level_reg <= '0;
            mode_reg <= '0;
            clean_reg <= '0;
            psamp_reg <= '0;
            pbad_reg <= '0;
            pcnt_reg <= '{default: '0};
            pim_reg <= '0;
            bpim_reg <= '0;
            upd_reg <= 1'b0;
            state_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
            prev_free_reg <= prev_free_next;
            rej_sum_reg <= rej_sum_next;
            level_reg <= level_next;
            mode_reg <= mode_next;
            clean_reg <= clean_next;
            psamp_reg <= psamp_next;
            pbad_reg <= pbad_next;
            pcnt_reg <= pcnt_next;
            pim_reg <= pim_next;
            bpim_reg <= bpim_next;
            if (cmd.eval)
            begin
                upd_reg <= fire_upd;
                state_reg <= fire_state && thresh_reg != '0;
            end
        end
    end

    // message snapshot taken at evaluation; mode is the one before any change
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            smsg_level_reg <= snap_level;
            smsg_cnt_reg <= snap_cnt;
            smsg_mode_reg <= mode_reg;
            util_reg <= util;
        end
    end

    assign status.need_init = !seen_reg;
    assign status.need_update = upd_reg;
    assign status.need_state = state_reg;

    // output register
    logic [127:0] word;
    logic [2:0]   kind_w;
    always_comb
    begin
        word = '0;
        kind_w = cmd.kind;
        unique case (cmd.kind)
            bcam_pkg::MSG_INIT:   word[26:3] = max_desc_reg;
            bcam_pkg::MSG_UPDATE:
            begin
                word[26:3] = free_ge ? 24'd0 : 24'(max_desc_reg - free_reg);
                word[58:27] = rej_sum_reg;
            end
            default:
            begin
                if (smsg_level_reg == 2'd0)
                begin
                    kind_w = bcam_pkg::MSG_CLEAR;
                    word[109:102] = clr_run_reg;
                end
                else
                begin
                    kind_w = (smsg_level_reg == 2'd1) ? bcam_pkg::MSG_WARNING
                                                      : bcam_pkg::MSG_ALERT;
                    word[65:59] = thresh_reg;
                    word[74:66] = smsg_cnt_reg[0];
                    word[83:75] = smsg_cnt_reg[1];
                    word[92:84] = smsg_cnt_reg[2];
                    word[94:93] = smsg_mode_reg;
                    word[101:95] = (smsg_mode_reg == 2'd0) ? util_reg : 7'd0;
                end
            end
        endcase
        word[2:0] = kind_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.emit)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data <= word;
            out_last <= cmd.last;
        end
    end

    alarm_only_up: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg != 2'd0 && level_next != level_reg) |-> (level_next == 2'd0 ||
        level_next > level_reg))
        else $error("alarm level dropped without a clear");
    no_emit_over_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.emit)
        else $error("message emitted over an untaken word");
    div_done_before_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> status.div_done)
        else $error("evaluation before division finished");
endmodule

@@ design/bcam_ctrl.sv @@
// controller: sequences division, evaluation and up to three message words
// depends on bcam_pkg
module bcam_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  bcam_pkg::dp_status_t status,
    input  logic                 out_busy,
    output logic                 in_ready,
    output bcam_pkg::dp_cmd_t    cmd
);
    bcam_pkg::ctrl_state_t state_reg, state_next;
    logic init_reg, init_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcam_pkg::ST_IDLE;
            init_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg <= init_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        init_next = init_reg;
        cmd = '0;
        cmd.kind = bcam_pkg::MSG_INIT;
        in_ready = 1'b0;
        unique case (state_reg)
            bcam_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    init_next = status.need_init;
                    state_next = bcam_pkg::ST_DIVIDE;
                end
            end
            bcam_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    cmd.div_step = 1'b0;
                    cmd.eval = 1'b1;
                    state_next = bcam_pkg::ST_EVAL;
                end
            end
            bcam_pkg::ST_EVAL:
            begin
                if (init_reg)
                    state_next = bcam_pkg::ST_EMIT_INIT;
                else if (status.need_update)
                    state_next = bcam_pkg::ST_EMIT_UPDATE;
                else if (status.need_state)
                    state_next = bcam_pkg::ST_EMIT_STATE;
                else
                    state_next = bcam_pkg::ST_IDLE;
            end
            bcam_pkg::ST_EMIT_INIT:
            begin
                if (!out_busy)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = bcam_pkg::MSG_INIT;
                    cmd.last = !status.need_update && !status.need_state;
                    state_next = status.need_update ? bcam_pkg::ST_EMIT_UPDATE :
                                 status.need_state ? bcam_pkg::ST_EMIT_STATE :
                                 bcam_pkg::ST_IDLE;
                end
            end
            bcam_pkg::ST_EMIT_UPDATE:
            begin
                if (!out_busy)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = bcam_pkg::MSG_UPDATE;
                    cmd.last = !status.need_state;
                    state_next = status.need_state ? bcam_pkg::ST_EMIT_STATE :
                                 bcam_pkg::ST_IDLE;
                end
            end
            bcam_pkg::ST_EMIT_STATE:
            begin
                if (!out_busy)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = bcam_pkg::MSG_CLEAR;
                    cmd.last = 1'b1;
                    state_next = bcam_pkg::ST_IDLE;
                end
            end
            default: state_next = bcam_pkg::ST_IDLE;
        endcase
    end

    ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == bcam_pkg::ST_IDLE)
        else $error("input taken outside idle");
    load_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == bcam_pkg::ST_DIVIDE)
        else $error("load did not start division");
    emit_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && state_reg == bcam_pkg::ST_EMIT_STATE) |-> cmd.last)
        else $error("state message not marked last");
endmodule

@@ design/buffer_congestion_alarm_monitor.sv @@
// top level of the buffer congestion alarm monitor
// instantiates bcam_ctrl and bcam_datapath; depends on bcam_pkg
//
// One input word is one periodic sample (free descriptors, rejected packets).
// The block works out utilization percent with a restoring divider that
// produces one quotient bit a cycle, then updates the alarm level and the
// period counters, then sends up to three message words: init (first sample
// only), update (free count changed or packets rejected), and one clear,
// warning or alert word. A sample occupies the block through the 31-step
// division, the evaluation and each message word, and for longer while the
// output stalls. A new sample is taken only after the previous one's words
// have all gone into the output register. Configuration writes are always
// accepted and must only be made while the block is idle.
module buffer_congestion_alarm_monitor (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // sample input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,   // free_descriptors[23:0], rejected_packets[55:24]
    // message output
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // msg_kind, descriptor_value, rejected_total,
                                         // threshold_echo, period_over_threshold,
                                         // period_rejecting, period_both, alert_rate,
                                         // utilization_pct, clear_run_echo
    output logic         m_axis_tlast    // last word of this sample
);
    bcam_pkg::dp_cmd_t    cmd;
    bcam_pkg::dp_status_t status;
    logic                 in_fire;
    logic [127:0]         word;

    assign cfg_ready = 1'b1;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata = word[111:0];

    bcam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .status   (status),
        .out_busy (m_axis_tvalid && !m_axis_tready),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    bcam_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_value (cfg_data),
        .free_in   (s_axis_tdata[23:0]),
        .rej_in    (s_axis_tdata[55:24]),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (word),
        .out_last  (m_axis_tlast)
    );

    word_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> word[127:111] == '0)
        else $error("padding bits set");
    stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed while stalled");
    no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("second sample taken during work");
endmodule
